### src/lpvd_pkg.sv
package lpvd_pkg;

	localparam int BYTE_W      = 8;
	localparam int COUNT_W     = 16;
	localparam int INDEX_W     = 16;
	localparam int KIND_W      = 2;
	localparam int REM_W       = 31;
	localparam int ACC_W       = 24;
	localparam int INDEX_BITS_DEF = 16;

	// m_axis_tdata: value_index, then out_byte
	localparam int OUT_DATA_W  = INDEX_W + BYTE_W;

	localparam logic [7:0] CODE_UNSUPPORTED = 8'd1;
	localparam logic [1:0] HDR_LAST_BYTE    = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA        = 2'd0,
		KIND_NULL        = 2'd1,
		KIND_EMPTY       = 2'd2,
		KIND_UNSUPPORTED = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_COMP = 5'b00001,
		PH_SIZE = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

endpackage

### src/length_prefixed_value_deframer_unit.sv
// A byte accepted on the input passes the input register, then the result register, on its
// way to its result word.
// Throughput: one byte per cycle; the parser state is updated by a single stage of counter
// and shift logic, so only backpressure on the result side slows the input.
// Reset: arst_n clears the parser state, the value count register and both valid flags.
// A byte that carries tlast returns the parser to its reset state; value_count is kept.
module length_prefixed_value_deframer_unit #(
	parameter int INDEX_BITS = lpvd_pkg::INDEX_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lpvd_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] in_byte
	input  logic                              s_axis_tlast,  // blob_end
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [lpvd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [15:0] value_index, [23:16] out_byte
	output logic [lpvd_pkg::KIND_W-1:0]       m_axis_tuser,  // [1:0] kind
	output logic                              m_axis_tlast,  // value_last
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lpvd_pkg::COUNT_W-1:0]      cfg_data
);
	import lpvd_pkg::*;

	localparam int MaskBits = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
	localparam logic [INDEX_W-1:0] IdxMask = INDEX_W'((17'd1 << MaskBits) - 17'd1);

	logic [COUNT_W-1:0] value_count_q;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               end_s1;

	phase_t             phase_q, phase_d;
	logic [1:0]         fcnt_q, fcnt_d;
	logic [ACC_W-1:0]   acc_q, acc_d;
	logic [REM_W-1:0]   rem_q, rem_d;
	logic [INDEX_W-1:0] idx_q, idx_d;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;

	logic               res_valid;
	kind_t              res_kind;
	logic [INDEX_W-1:0] res_idx;
	logic [BYTE_W-1:0]  res_byte;
	logic               res_last;

	logic               advance;
	logic [INDEX_W-1:0] idx_inc;
	logic               rem_le1;

	assign cfg_ready     = 1'b1;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	assign idx_inc = idx_q + 1'b1;
	assign rem_le1 = (rem_q <= REM_W'(1));

	always_comb begin
		phase_d   = phase_q;
		fcnt_d    = fcnt_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		idx_d     = idx_q;
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_idx   = idx_q & IdxMask;
		res_byte  = '0;
		res_last  = 1'b1;
		case (phase_q)
			PH_COMP: begin
				if (value_count_q == '0) begin
					phase_d = PH_DONE;
				end else if (byte_s1 == CODE_UNSUPPORTED) begin
					res_valid = 1'b1;
					res_kind  = KIND_UNSUPPORTED;
					res_idx   = '0;
					phase_d   = PH_DONE;
				end else begin
					phase_d = PH_SIZE;
					fcnt_d  = '0;
				end
			end
			PH_SIZE: begin
				if (fcnt_q == HDR_LAST_BYTE) begin
					fcnt_d  = '0;
					acc_d   = '0;
					phase_d = PH_LEN;
				end else begin
					fcnt_d = fcnt_q + 1'b1;
				end
			end
			PH_LEN: begin
				// The top length byte is never stored: its sign bit and low seven bits are
				// used directly when the field completes.
				if (fcnt_q == HDR_LAST_BYTE) begin
					fcnt_d = '0;
					if (byte_s1[7]) begin
						res_valid = 1'b1;
						res_kind  = KIND_NULL;
					end else if (acc_q == '0 && byte_s1 == '0) begin
						res_valid = 1'b1;
						res_kind  = KIND_EMPTY;
					end else begin
						rem_d   = {byte_s1[6:0], acc_q};
						phase_d = PH_DATA;
					end
					if (res_valid) begin
						idx_d   = idx_inc;
						acc_d   = '0;
						rem_d   = '0;
						phase_d = (idx_inc >= value_count_q) ? PH_DONE : PH_LEN;
					end
				end else begin
					case (fcnt_q)
						2'd0:    acc_d[7:0]   = byte_s1;
						2'd1:    acc_d[15:8]  = byte_s1;
						default: acc_d[23:16] = byte_s1;
					endcase
					fcnt_d = fcnt_q + 1'b1;
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				res_kind  = KIND_DATA;
				res_byte  = byte_s1;
				res_last  = rem_le1 || end_s1;
				if (rem_le1) begin
					idx_d   = idx_inc;
					fcnt_d  = '0;
					acc_d   = '0;
					rem_d   = '0;
					phase_d = (idx_inc >= value_count_q) ? PH_DONE : PH_LEN;
				end else begin
					rem_d = rem_q - 1'b1;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		if (end_s1) begin
			phase_d = PH_COMP;
			fcnt_d  = '0;
			acc_d   = '0;
			rem_d   = '0;
			idx_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_count_q <= '0;
			valid_s1      <= 1'b0;
			phase_q       <= PH_COMP;
			fcnt_q        <= '0;
			acc_q         <= '0;
			rem_q         <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				value_count_q <= cfg_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (valid_s1 && advance) begin
				phase_q <= phase_d;
				fcnt_q  <= fcnt_d;
				acc_q   <= acc_d;
				rem_q   <= rem_d;
				idx_q   <= idx_d;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
		if (advance && valid_s1 && res_valid) begin
			out_kind_q <= res_kind;
			out_idx_q  <= res_idx;
			out_byte_q <= res_byte;
			out_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_byte_q, out_idx_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_nondata_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != KIND_DATA |-> out_last_q)
		else $error("non-data result without value_last");

	a_nondata_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != KIND_DATA |-> out_byte_q == '0)
		else $error("non-data result carries a byte");

	a_unsupported_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_UNSUPPORTED |-> out_idx_q == '0)
		else $error("unsupported result with nonzero index");

	a_data_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("data phase with nothing remaining");

endmodule
